### hdl/lrog_pkg.sv
package lrog_pkg;

    localparam int GRID_SIDE_DEF  = 512;
    localparam int TURN_UNITS     = 102944;
    localparam int QUARTER_UNITS  = 25736;
    localparam int HALF_QUARTER   = 12868;
    localparam int DEG_UNITS      = 286;
    localparam int TURN_X3        = 308832;
    localparam int RECIP_QUARTER  = 166885;   // floor(2^32 / QUARTER_UNITS)
    localparam int BEAM_MIN_INDEX = 10;
    localparam int NEAR_STEP      = 2;
    localparam int FAR_STEP       = 10;
    localparam int CFG_DATA_W     = 17;
    localparam int CFG_INDEX_W    = 3;

    localparam logic [7:0] GRAY_UNKNOWN = 8'd127;
    localparam logic [7:0] GRAY_OCC     = 8'd1;
    localparam logic [7:0] GRAY_FREE    = 8'd253;
    localparam logic [7:0] GRAY_NONE    = 8'd0;

    localparam longint unsigned PI_Q30 = 64'd3373259426;

    typedef enum logic [1:0] {
        CELL_UNKNOWN = 2'd0,
        CELL_OCC     = 2'd1,
        CELL_FREE    = 2'd2
    } cell_t;

    typedef enum logic [2:0] {
        REG_ANGLE_STEP    = 3'd0,
        REG_HALF_APERTURE = 3'd1,
        REG_HALF_WIDTH    = 3'd2,
        REG_THICKNESS     = 3'd3,
        REG_CELLS_PER_CM  = 3'd4,
        REG_FAR_RANGE     = 3'd5,
        REG_ORIGIN_X      = 3'd6,
        REG_ORIGIN_Y      = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] angle_step;
        logic [16:0] half_aperture;
        logic [5:0]  beam_half_width_deg;
        logic [7:0]  wall_thickness_cm;
        logic [15:0] cells_per_cm;
        logic [12:0] far_range_cm;
        logic [8:0]  origin_x;
        logic [8:0]  origin_y;
    } cfg_t;

    typedef struct packed {
        logic [9:0]         beam_index;
        logic [12:0]        range_cm;
        logic signed [15:0] pose_x;
        logic signed [15:0] pose_y;
        logic signed [17:0] pose_heading;
    } beam_req_t;

    typedef struct packed {
        logic  en;
        cell_t data;
    } cell_wr_t;

    typedef logic signed [15:0] sin_tab_t [0:256];

    // Quarter-wave sine, Q1.14, from integer Taylor sums in Q30
    function automatic sin_tab_t build_sin_tab();
        sin_tab_t          tab;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint unsigned   pos;
        longint unsigned   neg;
        longint unsigned   rnd;
        for (int k = 0; k <= 256; k++) begin
            x    = (longint'(k) * PI_Q30) / 64'd512;
            x2   = (x * x) >> 30;
            term = x;
            pos  = x;
            neg  = 64'd0;
            // odd powers 3 to 17, signs alternating
            term = ((term * x2) >> 30) / 64'd6;
            neg  = neg + term;
            term = ((term * x2) >> 30) / 64'd20;
            pos  = pos + term;
            term = ((term * x2) >> 30) / 64'd42;
            neg  = neg + term;
            term = ((term * x2) >> 30) / 64'd72;
            pos  = pos + term;
            term = ((term * x2) >> 30) / 64'd110;
            neg  = neg + term;
            term = ((term * x2) >> 30) / 64'd156;
            pos  = pos + term;
            term = ((term * x2) >> 30) / 64'd210;
            neg  = neg + term;
            term = ((term * x2) >> 30) / 64'd272;
            pos  = pos + term;
            rnd    = ((pos - neg) + 64'd32768) >> 16;
            tab[k] = 16'(rnd);
        end
        return tab;
    endfunction

    localparam sin_tab_t SIN_TAB = build_sin_tab();

endpackage

### hdl/laser_ray_occupancy_grid.sv
// Laser-beam occupancy grid. Pulse start with req_type 0 to sweep one beam
// into the grid, or req_type 1 to read one cell; start is taken only while
// busy is low. Every item answers with exactly one result_strobe pulse and the
// result ports are valid only in that cycle, so the receiver must take it
// then. A read passes the registered memory output through the S_READ state
// and raises its registered result strobe after that. An insert first reduces
// its start angle by restoring steps, then per swept degree looks up sine and
// cosine and writes at most one cell per range step along the ray (range + thickness/2
// steps near, (3*range + 5*thickness)/10 steps far), since the grid memory
// takes one cell write per cycle, before advancing to the next degree;
// the mapping pipeline then drains. After reset busy stays high while all
// GRID_SIDE*GRID_SIDE cells (262144 at 512) become unknown. Configuration
// writes take effect at once; issue them only while the block is idle and no
// result is pending, since an insert reads the registers throughout its sweep.
module laser_ray_occupancy_grid
#(
    parameter int GRID_SIDE = lrog_pkg::GRID_SIDE_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                req_type,
    input  logic [9:0]                          beam_index,
    input  logic [12:0]                         range_cm,
    input  logic signed [15:0]                  pose_x,
    input  logic signed [15:0]                  pose_y,
    input  logic signed [17:0]                  pose_heading,
    input  logic [8:0]                          read_col,
    input  logic [8:0]                          read_row,
    output logic                                result_strobe,
    output logic                                result_kind,
    output logic [7:0]                          gray_value,
    input  logic                                cfg_we,
    input  logic [lrog_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lrog_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int ADDR_W = $clog2(GRID_SIDE * GRID_SIDE);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_READ   = 3'b010,
        S_INSERT = 3'b100
    } top_state_t;

    top_state_t          state_reg, state_next;
    lrog_pkg::cfg_t      cfg_reg;
    logic                strobe_reg, strobe_next;
    logic                kind_reg, kind_next;
    logic [7:0]          gray_reg, gray_next;
    logic                rd_ok_reg;

    lrog_pkg::beam_req_t req;
    lrog_pkg::cell_wr_t  wr;
    logic [ADDR_W-1:0]   wr_addr;
    logic [ADDR_W-1:0]   rd_addr;
    logic                rd_en;
    logic                rd_ok;
    lrog_pkg::cell_t     rd_data;
    logic                clearing;
    logic                accept;
    logic                ray_start;
    logic                ray_done;

    assign busy   = clearing || state_reg != S_IDLE;
    assign accept = start && !busy;

    assign req = '{beam_index: beam_index, range_cm: range_cm, pose_x: pose_x,
                   pose_y: pose_y, pose_heading: pose_heading};

    // cells outside the grid read as unknown without touching memory
    assign rd_ok     = 32'(read_col) < 32'(GRID_SIDE) && 32'(read_row) < 32'(GRID_SIDE);
    assign rd_addr   = ADDR_W'(read_row) * ADDR_W'(GRID_SIDE) + ADDR_W'(read_col);
    assign rd_en     = accept && req_type && rd_ok;
    assign ray_start = accept && !req_type;

    lrog_ray #(.GRID_SIDE(GRID_SIDE)) u_ray
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (ray_start),
        .req     (req),
        .cfg     (cfg_reg),
        .wr      (wr),
        .wr_addr (wr_addr),
        .done    (ray_done)
    );

    lrog_grid #(.GRID_SIDE(GRID_SIDE)) u_grid
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (wr),
        .wr_addr  (wr_addr),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .clearing (clearing)
    );

    always_comb
    begin
        state_next  = state_reg;
        strobe_next = 1'b0;
        kind_next   = kind_reg;
        gray_next   = gray_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = req_type ? S_READ : S_INSERT;
            end
            S_READ:
            begin
                // memory data lands this cycle; present it next
                strobe_next = 1'b1;
                kind_next   = 1'b1;
                gray_next   = lrog_pkg::GRAY_UNKNOWN;
                if (rd_ok_reg)
                begin
                    case (rd_data)
                        lrog_pkg::CELL_OCC:  gray_next = lrog_pkg::GRAY_OCC;
                        lrog_pkg::CELL_FREE: gray_next = lrog_pkg::GRAY_FREE;
                        default:             gray_next = lrog_pkg::GRAY_UNKNOWN;
                    endcase
                end
                state_next = S_IDLE;
            end
            S_INSERT:
            begin
                if (ray_done)
                begin
                    strobe_next = 1'b1;
                    kind_next   = 1'b0;
                    gray_next   = lrog_pkg::GRAY_NONE;
                    state_next  = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            strobe_reg <= 1'b0;
            cfg_reg    <= '{angle_step: 16'd101, half_aperture: 17'd34315,
                            beam_half_width_deg: 6'd2, wall_thickness_cm: 8'd10,
                            cells_per_cm: 16'd13107, far_range_cm: 13'd2000,
                            origin_x: 9'd256, origin_y: 9'd256};
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
            if (cfg_we)
            begin
                case (lrog_pkg::cfg_index_t'(cfg_index))
                    lrog_pkg::REG_ANGLE_STEP:    cfg_reg.angle_step <= cfg_data[15:0];
                    lrog_pkg::REG_HALF_APERTURE: cfg_reg.half_aperture <= cfg_data;
                    lrog_pkg::REG_HALF_WIDTH:    cfg_reg.beam_half_width_deg <= cfg_data[5:0];
                    lrog_pkg::REG_THICKNESS:     cfg_reg.wall_thickness_cm <= cfg_data[7:0];
                    lrog_pkg::REG_CELLS_PER_CM:  cfg_reg.cells_per_cm <= cfg_data[15:0];
                    lrog_pkg::REG_FAR_RANGE:     cfg_reg.far_range_cm <= cfg_data[12:0];
                    lrog_pkg::REG_ORIGIN_X:      cfg_reg.origin_x <= cfg_data[8:0];
                    lrog_pkg::REG_ORIGIN_Y:      cfg_reg.origin_y <= cfg_data[8:0];
                    default:                     cfg_reg <= cfg_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        gray_reg <= gray_next;
        if (accept)
            rd_ok_reg <= rd_ok;
    end

    assign result_strobe = strobe_reg;
    assign result_kind   = kind_reg;
    assign gray_value    = gray_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("busy not raised after an item was taken");

    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |=> !result_strobe)
        else $error("result strobe held for more than one cycle");

    a_insert_gray: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !result_kind |-> gray_value == lrog_pkg::GRAY_NONE)
        else $error("insert result carries a gray value");

    a_no_write_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !wr.en && state_reg == S_IDLE)
        else $error("grid written or item taken during clearing");

endmodule

### hdl/lrog_trig.sv
module lrog_trig
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [16:0]        angle,
    output logic               out_valid,
    output logic signed [15:0] sin_q14
);

    localparam logic [16:0] Q1 = 17'(lrog_pkg::QUARTER_UNITS);
    localparam logic [16:0] Q2 = 17'(2 * lrog_pkg::QUARTER_UNITS);
    localparam logic [16:0] Q3 = 17'(3 * lrog_pkg::QUARTER_UNITS);

    logic [3:0]         v_reg;
    logic [1:0]         quad_reg [0:2];
    logic [22:0]        num_reg [0:2];
    logic [40:0]        prod_reg;
    logic [8:0]         qe_reg;
    logic [23:0]        qm_reg;
    logic signed [15:0] sin_reg;

    logic [1:0]  quad;
    logic [16:0] t_raw;
    logic [14:0] t_fold;
    logic [22:0] num;
    logic [22:0] rem;
    logic [8:0]  idx;
    logic signed [15:0] mag;

    // fold into the first quadrant
    always_comb
    begin
        if (angle < Q1)
        begin
            quad  = 2'd0;
            t_raw = angle;
        end
        else if (angle < Q2)
        begin
            quad  = 2'd1;
            t_raw = angle - Q1;
        end
        else if (angle < Q3)
        begin
            quad  = 2'd2;
            t_raw = angle - Q2;
        end
        else
        begin
            quad  = 2'd3;
            t_raw = angle - Q3;
        end
        if (quad[0])
            t_fold = 15'(Q1 - t_raw);
        else
            t_fold = t_raw[14:0];
        num = {t_fold, 8'd0} + 23'(lrog_pkg::HALF_QUARTER);
    end

    always_comb
    begin
        rem = num_reg[2] - qm_reg[22:0];
        if (rem >= 23'(lrog_pkg::QUARTER_UNITS))
            idx = qe_reg + 9'd1;
        else
            idx = qe_reg;
        mag = lrog_pkg::SIN_TAB[idx];
    end

    always_ff @(posedge clk)
    begin
        quad_reg[0] <= quad;
        num_reg[0]  <= num;
        quad_reg[1] <= quad_reg[0];
        prod_reg    <= 41'(num_reg[0]) * 41'(lrog_pkg::RECIP_QUARTER);
        num_reg[1]  <= num_reg[0];
        quad_reg[2] <= quad_reg[1];
        num_reg[2]  <= num_reg[1];
        qe_reg      <= prod_reg[40:32];
        qm_reg      <= 24'(prod_reg[40:32]) * 24'(lrog_pkg::QUARTER_UNITS);
        sin_reg     <= quad_reg[2][1] ? -mag : mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[2:0], in_valid};
    end

    assign out_valid = v_reg[3];
    assign sin_q14   = sin_reg;

endmodule

### hdl/lrog_grid.sv
module lrog_grid
#(
    parameter int GRID_SIDE = lrog_pkg::GRID_SIDE_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  lrog_pkg::cell_wr_t                   wr,
    input  logic [$clog2(GRID_SIDE*GRID_SIDE)-1:0] wr_addr,
    input  logic                                 rd_en,
    input  logic [$clog2(GRID_SIDE*GRID_SIDE)-1:0] rd_addr,
    output lrog_pkg::cell_t                      rd_data,
    output logic                                 clearing
);

    localparam int DEPTH  = GRID_SIDE * GRID_SIDE;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [1:0]        mem [0:DEPTH-1];
    logic [1:0]        rd_q_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;
    logic              clr_active_reg;
    logic              clr_active_next;
    logic              we;
    logic [ADDR_W-1:0] wa;
    logic [1:0]        wd;

    // sweep every entry to unknown after reset
    always_comb
    begin
        clr_addr_next   = clr_addr_reg;
        clr_active_next = clr_active_reg;
        if (clr_active_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                clr_active_next = 1'b0;
        end
        we = clr_active_reg | wr.en;
        wa = clr_active_reg ? clr_addr_reg : wr_addr;
        wd = clr_active_reg ? lrog_pkg::CELL_UNKNOWN : wr.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg   <= '0;
            clr_active_reg <= 1'b1;
        end
        else
        begin
            clr_addr_reg   <= clr_addr_next;
            clr_active_reg <= clr_active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        if (rd_en)
            rd_q_reg <= mem[rd_addr];
    end

    assign rd_data  = lrog_pkg::cell_t'(rd_q_reg);
    assign clearing = clr_active_reg;

endmodule

### hdl/lrog_ray.sv
module lrog_ray
#(
    parameter int GRID_SIDE = lrog_pkg::GRID_SIDE_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  lrog_pkg::beam_req_t                    req,
    input  lrog_pkg::cfg_t                         cfg,
    output lrog_pkg::cell_wr_t                     wr,
    output logic [$clog2(GRID_SIDE*GRID_SIDE)-1:0] wr_addr,
    output logic                                   done
);

    localparam int ADDR_W = $clog2(GRID_SIDE * GRID_SIDE);
    localparam int SIDE_W = $clog2(GRID_SIDE);
    localparam logic signed [49:0] LIM = 50'(GRID_SIDE) <<< 30;
    localparam logic [27:0] TURN28 = 28'(lrog_pkg::TURN_UNITS);
    localparam logic [16:0] TURN17 = 17'(lrog_pkg::TURN_UNITS);

    typedef enum logic [5:0] {
        R_IDLE   = 6'b000001,
        R_PREP   = 6'b000010,
        R_REDUCE = 6'b000100,
        R_TRIG   = 6'b001000,
        R_SWEEP  = 6'b010000,
        R_DRAIN  = 6'b100000
    } ray_state_t;

    ray_state_t         state_reg, state_next;
    logic [25:0]        prod_reg;
    logic signed [17:0] hd_reg;
    logic signed [15:0] px_reg, py_reg;
    logic               far_reg;
    logic [14:0]        lim_reg;
    logic [3:0]         kstep_reg;
    logic signed [15:0] occ_th_reg;
    logic [27:0]        red_reg, red_next;
    logic [3:0]         k_reg, k_next;
    logic [16:0]        p_reg, p_next;
    logic [6:0]         d_reg, d_next;
    logic [1:0]         issue_reg, issue_next;
    logic               have_s_reg, have_s_next;
    logic signed [15:0] s_reg, s_next;
    logic signed [15:0] c_reg, c_next;
    logic signed [30:0] ax_reg, ax_next;
    logic signed [30:0] ay_reg, ay_next;
    logic [15:0]        rk_reg, rk_next;

    logic               m_v_reg;
    logic               m_occ_reg;
    logic signed [47:0] mx_reg, my_reg;
    lrog_pkg::cell_wr_t wr_reg;
    logic [ADDR_W-1:0]  wr_addr_reg;

    logic               trig_in_v;
    logic [16:0]        trig_angle;
    logic               trig_out_v;
    logic signed [15:0] trig_out;
    logic [16:0]        p_cos;
    logic [17:0]        p_sum;
    logic [17:0]        p_adv;
    logic [27:0]        red_sub;
    logic signed [28:0] base;
    logic               issue;
    logic               done_next;
    logic [6:0]         d_last;
    logic signed [49:0] cx;
    logic signed [49:0] cy;

    lrog_trig u_trig
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (trig_in_v),
        .angle     (trig_angle),
        .out_valid (trig_out_v),
        .sin_q14   (trig_out)
    );

    always_comb
    begin
        p_sum = 18'(p_reg) + 18'(lrog_pkg::QUARTER_UNITS);
        p_cos = (p_sum >= 18'(TURN17)) ? 17'(p_sum - 18'(TURN17)) : p_sum[16:0];
        p_adv = 18'(p_reg) + 18'(lrog_pkg::DEG_UNITS);
        red_sub = TURN28 << k_reg;
        base = 29'(prod_reg) + 29'(hd_reg) + 29'(lrog_pkg::TURN_X3)
             - 29'(cfg.half_aperture)
             - 29'(15'(cfg.beam_half_width_deg) * 15'(lrog_pkg::DEG_UNITS));
        d_last = {cfg.beam_half_width_deg, 1'b0} - 7'd1;
    end

    always_comb
    begin
        state_next  = state_reg;
        red_next    = red_reg;
        k_next      = k_reg;
        p_next      = p_reg;
        d_next      = d_reg;
        issue_next  = issue_reg;
        have_s_next = have_s_reg;
        s_next      = s_reg;
        c_next      = c_reg;
        ax_next     = ax_reg;
        ay_next     = ay_reg;
        rk_next     = rk_reg;
        trig_in_v   = 1'b0;
        trig_angle  = p_reg;
        issue       = 1'b0;
        done_next   = 1'b0;
        case (state_reg)
            R_IDLE:
            begin
                if (start)
                begin
                    if (req.beam_index < 10'(lrog_pkg::BEAM_MIN_INDEX) ||
                        cfg.beam_half_width_deg == '0)
                        state_next = R_DRAIN;
                    else
                        state_next = R_PREP;
                end
            end
            R_PREP:
            begin
                red_next   = 28'(base);
                k_next     = 4'd10;
                d_next     = '0;
                state_next = R_REDUCE;
            end
            R_REDUCE:
            begin
                // one restoring step per cycle, turn * 2^k
                if (red_reg >= red_sub)
                    red_next = red_reg - red_sub;
                k_next = k_reg - 4'd1;
                if (k_reg == 4'd0)
                begin
                    p_next      = red_next[16:0];
                    issue_next  = 2'd0;
                    have_s_next = 1'b0;
                    state_next  = R_TRIG;
                end
            end
            R_TRIG:
            begin
                // sine first, then cosine in the following cycle
                if (issue_reg == 2'd0)
                begin
                    trig_in_v  = 1'b1;
                    trig_angle = p_reg;
                    issue_next = 2'd1;
                end
                else if (issue_reg == 2'd1)
                begin
                    trig_in_v  = 1'b1;
                    trig_angle = p_cos;
                    issue_next = 2'd2;
                end
                if (trig_out_v)
                begin
                    if (!have_s_reg)
                    begin
                        s_next      = trig_out;
                        have_s_next = 1'b1;
                    end
                    else
                    begin
                        c_next     = trig_out;
                        ax_next    = 31'(px_reg) * 31'sd16384 + 31'(trig_out);
                        ay_next    = 31'(py_reg) * 31'sd16384 + 31'(s_reg);
                        rk_next    = 16'(kstep_reg);
                        state_next = R_SWEEP;
                    end
                end
            end
            R_SWEEP:
            begin
                if (rk_reg < 16'(lim_reg))
                begin
                    issue   = 1'b1;
                    ax_next = ax_reg + 31'(c_reg);
                    ay_next = ay_reg + 31'(s_reg);
                    rk_next = rk_reg + 16'(kstep_reg);
                end
                else if (d_reg == d_last)
                    state_next = R_DRAIN;
                else
                begin
                    d_next      = d_reg + 7'd1;
                    p_next      = (p_adv >= 18'(TURN17)) ? 17'(p_adv - 18'(TURN17))
                                                         : p_adv[16:0];
                    issue_next  = 2'd0;
                    have_s_next = 1'b0;
                    state_next  = R_TRIG;
                end
            end
            R_DRAIN:
            begin
                if (!m_v_reg && !wr_reg.en)
                begin
                    done_next  = 1'b1;
                    state_next = R_IDLE;
                end
            end
            default:
                state_next = R_IDLE;
        endcase
    end

    assign cx = 50'(mx_reg) + (50'(cfg.origin_x) <<< 30);
    assign cy = 50'(my_reg) + (50'(cfg.origin_y) <<< 30);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= R_IDLE;
            m_v_reg    <= 1'b0;
            wr_reg     <= '{en: 1'b0, data: lrog_pkg::CELL_UNKNOWN};
            done       <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            m_v_reg    <= issue;
            done       <= done_next;
            // keep only points strictly inside the grid on both axes
            wr_reg.en  <= m_v_reg && cx > 50'sd0 && cx < LIM &&
                          cy > 50'sd0 && cy < LIM;
            if (m_v_reg)
                wr_reg.data <= m_occ_reg ? lrog_pkg::CELL_OCC : lrog_pkg::CELL_FREE;
        end
    end

    always_ff @(posedge clk)
    begin
        red_reg    <= red_next;
        k_reg      <= k_next;
        p_reg      <= p_next;
        d_reg      <= d_next;
        issue_reg  <= issue_next;
        have_s_reg <= have_s_next;
        s_reg      <= s_next;
        c_reg      <= c_next;
        ax_reg     <= ax_next;
        ay_reg     <= ay_next;
        rk_reg     <= rk_next;
        if (state_reg == R_IDLE && start)
        begin
            prod_reg   <= 26'(req.beam_index) * 26'(cfg.angle_step);
            hd_reg     <= req.pose_heading;
            px_reg     <= req.pose_x;
            py_reg     <= req.pose_y;
            far_reg    <= req.range_cm >= cfg.far_range_cm;
            if (req.range_cm >= cfg.far_range_cm)
            begin
                lim_reg   <= 15'(req.range_cm) * 15'd3 + 15'(cfg.wall_thickness_cm) * 15'd5;
                kstep_reg <= 4'(lrog_pkg::FAR_STEP);
            end
            else
            begin
                lim_reg   <= {1'b0, req.range_cm, 1'b0} + 15'(cfg.wall_thickness_cm);
                kstep_reg <= 4'(lrog_pkg::NEAR_STEP);
            end
            occ_th_reg <= $signed({2'b0, req.range_cm, 1'b0})
                        - $signed(16'(cfg.wall_thickness_cm));
        end
        mx_reg    <= 48'(ax_reg * $signed({1'b0, cfg.cells_per_cm}));
        my_reg    <= 48'(ay_reg * $signed({1'b0, cfg.cells_per_cm}));
        m_occ_reg <= !far_reg && $signed(rk_reg) > occ_th_reg;
        wr_addr_reg <= ADDR_W'(cy[30 +: SIDE_W]) * ADDR_W'(GRID_SIDE)
                     + ADDR_W'(cx[30 +: SIDE_W]);
    end

    assign wr      = wr_reg;
    assign wr_addr = wr_addr_reg;

endmodule

### sim/lrog_checker.sv
`timescale 1ns / 1ps

module lrog_checker
    import lrog_pkg::*;
#(
    parameter int GRID_SIDE = GRID_SIDE_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   busy,
    input  logic                   req_type,
    input  logic [9:0]             beam_index,
    input  logic [12:0]            range_cm,
    input  logic signed [15:0]     pose_x,
    input  logic signed [15:0]     pose_y,
    input  logic signed [17:0]     pose_heading,
    input  logic [8:0]             read_col,
    input  logic [8:0]             read_row,
    input  logic                   result_strobe,
    input  logic                   result_kind,
    input  logic [7:0]             gray_value,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     fail_count,
    output int                     pending
);

    typedef struct {
        logic       kind;
        logic [7:0] gray;
    } answer_t;

    cell_t    belief [0:GRID_SIDE*GRID_SIDE-1];
    int       sine_q14 [0:256];
    answer_t  answers_due [$];
    cfg_t     regs;

    function automatic int taylor_sine(int k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned acc_pos;
        longint unsigned acc_neg;
        x       = (longint'(k) * PI_Q30) / 512;
        x2      = (x * x) >> 30;
        term    = x;
        acc_pos = x;
        acc_neg = 0;
        for (int n = 1; n <= 15; n += 2)
        begin
            term = ((term * x2) >> 30) / longint'((n + 1) * (n + 2));
            if (((n - 1) / 2) % 2 == 0)
                acc_neg += term;
            else
                acc_pos += term;
        end
        return int'(((acc_pos - acc_neg) + 64'd32768) >> 16);
    endfunction

    function automatic int trig_q14(longint phi);
        longint p;
        longint q;
        longint t;
        longint idx;
        p = phi % TURN_UNITS;
        if (p < 0)
            p += TURN_UNITS;
        q = p / QUARTER_UNITS;
        t = p - q * QUARTER_UNITS;
        if (q == 1 || q == 3)
            t = QUARTER_UNITS - t;
        idx = (t * 256 + QUARTER_UNITS / 2) / QUARTER_UNITS;
        if (idx < 0)
            idx = 0;
        if (idx > 256)
            idx = 256;
        return (q >= 2) ? -sine_q14[idx] : sine_q14[idx];
    endfunction

    task automatic sweep_beam(longint idx, longint rng, longint px, longint py,
                              longint hd);
        longint thick;
        longint hw;
        longint base;
        longint phi;
        longint mx;
        longint my;
        longint lim;
        int     s;
        int     c;
        bit     far;
        thick = regs.wall_thickness_cm;
        hw    = regs.beam_half_width_deg;
        far   = rng >= longint'(regs.far_range_cm);
        lim   = longint'(GRID_SIDE) << 30;
        base  = hd + idx * longint'(regs.angle_step) - longint'(regs.half_aperture);
        for (longint d = -hw; d < hw; d++)
        begin
            phi = base + d * DEG_UNITS;
            s   = trig_q14(phi);
            c   = trig_q14(phi + QUARTER_UNITS);
            for (longint r = 1;
                 far ? (10 * r < 3 * rng + 5 * thick) : (2 * r < 2 * rng + thick);
                 r++)
            begin
                mx = (r * c + px * 16384) * longint'(regs.cells_per_cm)
                     + (longint'(regs.origin_x) << 30);
                my = (r * s + py * 16384) * longint'(regs.cells_per_cm)
                     + (longint'(regs.origin_y) << 30);
                if (mx > 0 && mx < lim && my > 0 && my < lim)
                begin
                    if (!far && 2 * r > 2 * rng - thick)
                        belief[(my >> 30) * GRID_SIDE + (mx >> 30)] = CELL_OCC;
                    else
                        belief[(my >> 30) * GRID_SIDE + (mx >> 30)] = CELL_FREE;
                end
            end
        end
    endtask

    initial
    begin
        for (int k = 0; k <= 256; k++)
            sine_q14[k] = taylor_sine(k);
    end

    assign pending = answers_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        answer_t got;
        answer_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < GRID_SIDE * GRID_SIDE; i++)
                belief[i] = CELL_UNKNOWN;
            regs.angle_step          = 16'd101;
            regs.half_aperture       = 17'd34315;
            regs.beam_half_width_deg = 6'd2;
            regs.wall_thickness_cm   = 8'd10;
            regs.cells_per_cm        = 16'd13107;
            regs.far_range_cm        = 13'd2000;
            regs.origin_x            = 9'd256;
            regs.origin_y            = 9'd256;
            answers_due.delete();
            fail_count = 0;
        end
        else
        begin
            // Retire the older result before predicting the newly taken item
            if (result_strobe)
            begin
                got.kind = result_kind;
                got.gray = gray_value;
                if (answers_due.size() == 0)
                begin
                    $error("unexpected result: kind %0d gray %0d", got.kind, got.gray);
                    fail_count++;
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (got.kind !== want.kind)
                    begin
                        $error("result_kind: expected %0d, got %0d", want.kind, got.kind);
                        fail_count++;
                    end
                    if (got.gray !== want.gray)
                    begin
                        $error("gray_value: expected %0d, got %0d", want.gray, got.gray);
                        fail_count++;
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    REG_ANGLE_STEP:    regs.angle_step          = cfg_data[15:0];
                    REG_HALF_APERTURE: regs.half_aperture       = cfg_data[16:0];
                    REG_HALF_WIDTH:    regs.beam_half_width_deg = cfg_data[5:0];
                    REG_THICKNESS:     regs.wall_thickness_cm   = cfg_data[7:0];
                    REG_CELLS_PER_CM:  regs.cells_per_cm        = cfg_data[15:0];
                    REG_FAR_RANGE:     regs.far_range_cm        = cfg_data[12:0];
                    REG_ORIGIN_X:      regs.origin_x            = cfg_data[8:0];
                    REG_ORIGIN_Y:      regs.origin_y            = cfg_data[8:0];
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                if (req_type == 1'b0)
                begin
                    if (beam_index >= BEAM_MIN_INDEX)
                        sweep_beam(beam_index, range_cm, pose_x, pose_y, pose_heading);
                    want.kind = 1'b0;
                    want.gray = GRAY_NONE;
                end
                else
                begin
                    want.kind = 1'b1;
                    want.gray = GRAY_UNKNOWN;
                    if (read_col < GRID_SIDE && read_row < GRID_SIDE)
                    begin
                        case (belief[read_row * GRID_SIDE + read_col])
                            CELL_OCC:  want.gray = GRAY_OCC;
                            CELL_FREE: want.gray = GRAY_FREE;
                            default: ;
                        endcase
                    end
                end
                answers_due.push_back(want);
            end
        end
    end

endmodule

### sim/laser_ray_occupancy_grid_test.sv
`timescale 1ns / 1ps

module laser_ray_occupancy_grid_test;
    import lrog_pkg::*;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic                   req_type = 1'b0;
    logic [9:0]             beam_index = '0;
    logic [12:0]            range_cm = '0;
    logic signed [15:0]     pose_x = '0;
    logic signed [15:0]     pose_y = '0;
    logic signed [17:0]     pose_heading = '0;
    logic [8:0]             read_col = '0;
    logic [8:0]             read_row = '0;
    logic                   result_strobe;
    logic                   result_kind;
    logic [7:0]             gray_value;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    int                     fail_count;
    int                     pending;

    // Mirror of the mapping registers, used to aim reads at swept cells and to pick ranges
    int shadow_cpc = 13107;
    int shadow_ox  = 256;
    int shadow_oy  = 256;
    int shadow_hw  = 2;
    // When set, items follow one another with no gap
    bit back_to_back = 1'b0;

    always #4 clk = ~clk;

    laser_ray_occupancy_grid dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .beam_index    (beam_index),
        .range_cm      (range_cm),
        .pose_x        (pose_x),
        .pose_y        (pose_y),
        .pose_heading  (pose_heading),
        .read_col      (read_col),
        .read_row      (read_row),
        .result_strobe (result_strobe),
        .result_kind   (result_kind),
        .gray_value    (gray_value),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    lrog_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .beam_index    (beam_index),
        .range_cm      (range_cm),
        .pose_x        (pose_x),
        .pose_y        (pose_y),
        .pose_heading  (pose_heading),
        .read_col      (read_col),
        .read_row      (read_row),
        .result_strobe (result_strobe),
        .result_kind   (result_kind),
        .gray_value    (gray_value),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // Present one item after a random gap and hold it until the block takes it
    task automatic send_item(logic req, int idx, int rng, int px, int py, int hd,
                             int col, int row);
        int gap;
        gap = back_to_back ? 0 : $urandom_range(0, 11);
        @(negedge clk);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_type     = req;
        beam_index   = 10'(idx);
        range_cm     = 13'(rng);
        pose_x       = 16'(px);
        pose_y       = 16'(py);
        pose_heading = 18'(hd);
        read_col     = 9'(col);
        read_row     = 9'(row);
        start        = 1'b1;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic insert_beam(int idx, int rng, int px, int py, int hd);
        send_item(1'b0, idx, rng, px, py, hd, $urandom_range(0, 511),
                  $urandom_range(0, 511));
    endtask

    task automatic read_cell(int col, int row);
        send_item(1'b1, $urandom_range(0, 1023), $urandom_range(0, 8191),
                  $urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 262143), col, row);
    endtask

    // Read a cell close to where a beam from (px, py) would land
    task automatic read_near(int px, int py, int rng);
        int dx;
        int dy;
        dx = px + $urandom_range(0, 2 * rng + 2) - rng - 1;
        dy = py + $urandom_range(0, 2 * rng + 2) - rng - 1;
        read_cell((shadow_ox + int'((longint'(dx) * shadow_cpc) >>> 16)) & 511,
                  (shadow_oy + int'((longint'(dy) * shadow_cpc) >>> 16)) & 511);
    endtask

    // Write one register once the block has drained
    task automatic write_reg(cfg_index_t idx, int value);
        @(negedge clk);
        start = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = CFG_DATA_W'(value);
        @(negedge clk);
        cfg_we    = 1'b0;
        case (idx)
            REG_CELLS_PER_CM: shadow_cpc = value;
            REG_ORIGIN_X:     shadow_ox  = value;
            REG_ORIGIN_Y:     shadow_oy  = value;
            REG_HALF_WIDTH:   shadow_hw  = value;
            default: ;
        endcase
    endtask

    // Draw a mostly on-grid pose, with occasional full-range poses
    function automatic int pick_pose();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 65535) - 32768;
        return $urandom_range(0, 1000) - 500;
    endfunction

    initial
    begin
        int px;
        int py;
        int rng;
        int hd;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Fresh grid reads as unknown at two corners and the centre
        read_cell(0, 0);
        read_cell(511, 511);
        read_cell(256, 256);
        // Low beam index writes nothing
        insert_beam(9, 100, 0, 0, 0);
        read_near(0, 0, 20);
        // Default settings, a near beam, then reads around it
        insert_beam(340, 50, 0, 0, 0);
        read_near(0, 0, 50);
        read_near(0, 0, 50);
        // Zero range and largest heading swings
        insert_beam(1023, 0, 100, -100, 102944);
        insert_beam(10, 300, -200, 200, -102944);
        read_near(-200, 200, 300);
        // Far beam at the largest range: free only
        write_reg(REG_HALF_WIDTH, 1);
        insert_beam(500, 8191, 0, 0, 0);
        read_near(0, 0, 3000);
        read_near(0, 0, 3000);
        // Near beam just under the largest far threshold
        write_reg(REG_FAR_RANGE, 8191);
        write_reg(REG_THICKNESS, 255);
        insert_beam(400, 8190, -32768, 32767, 0);
        read_near(0, 0, 500);
        // Zero half width sweeps no offsets
        write_reg(REG_HALF_WIDTH, 0);
        insert_beam(600, 200, 0, 0, 5000);
        read_near(0, 0, 200);
        // Wide beam, thin wall, finest and coarsest scale, edge origins
        write_reg(REG_HALF_WIDTH, 45);
        write_reg(REG_THICKNESS, 0);
        write_reg(REG_FAR_RANGE, 0);
        write_reg(REG_CELLS_PER_CM, 65535);
        write_reg(REG_ORIGIN_X, 0);
        write_reg(REG_ORIGIN_Y, 511);
        write_reg(REG_ANGLE_STEP, 65535);
        write_reg(REG_HALF_APERTURE, 102944);
        insert_beam(700, 40, 20, -20, 0);
        read_near(20, -20, 40);
        write_reg(REG_CELLS_PER_CM, 1);
        write_reg(REG_ANGLE_STEP, 0);
        write_reg(REG_HALF_APERTURE, 0);
        write_reg(REG_FAR_RANGE, 2000);
        insert_beam(12, 60, 32767, -32768, 0);
        read_cell(0, 511);

        // Random phases, each with its own register setting
        for (int phase = 0; phase < 6; phase++)
        begin
            write_reg(REG_ANGLE_STEP, $urandom_range(0, 65535));
            write_reg(REG_HALF_APERTURE, $urandom_range(0, 102944));
            write_reg(REG_HALF_WIDTH, (phase == 3) ? 45 : $urandom_range(0, 5));
            write_reg(REG_THICKNESS, $urandom_range(0, 255));
            write_reg(REG_CELLS_PER_CM, (phase == 1) ? 65535 : $urandom_range(1, 65535));
            write_reg(REG_FAR_RANGE, $urandom_range(0, 8191));
            write_reg(REG_ORIGIN_X, (phase == 2) ? 511 : $urandom_range(0, 511));
            write_reg(REG_ORIGIN_Y, (phase == 2) ? 0 : $urandom_range(0, 511));
            back_to_back = (phase % 3 == 1);
            for (int n = 0; n < 8; n++)
            begin
                px  = pick_pose();
                py  = pick_pose();
                hd  = $urandom_range(0, 205888) - 102944;
                // Keep ranges short; allow a long one only on narrow beams
                if (shadow_hw <= 3 && $urandom_range(0, 15) == 0)
                    rng = $urandom_range(0, 8191);
                else
                    rng = $urandom_range(0, (shadow_hw > 5) ? 60 : 400);
                insert_beam($urandom_range(0, 1023), rng, px, py, hd);
                read_near(px, py, (rng > 600) ? 600 : rng);
                if ($urandom_range(0, 1) == 0)
                    read_near(px, py, (rng > 600) ? 600 : rng);
                if ($urandom_range(0, 5) == 0)
                    read_cell($urandom_range(0, 511), $urandom_range(0, 511));
            end
        end

        @(negedge clk);
        start = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Hard stop well past the slowest legal run, clearing pass included
    initial
    begin
        #160000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
